// ===== rtl/istu_pkg.sv =====
// ---------------------------------------------------------------------------
// istu_pkg: shared types and constants of the integer set table
// Holds the table size, the request and status codes, the token word that
// travels along the cell chain and the command word broadcast to its cells.
// ---------------------------------------------------------------------------
`default_nettype none

package istu_pkg;

  // Table size and derived widths
  localparam int unsigned Capacity = 64;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ValueW   = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 7;

  // Request codes
  localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindW-1:0] KIND_ERASE  = 2'd1;
  localparam logic [KindW-1:0] KIND_QUERY  = 2'd2;

  // Result codes
  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_MISS = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

  // Search token handed from cell to cell
  typedef struct packed {
    logic active;  // token sits at this cell's input
    logic hit;     // an earlier cell holds the value
    logic free;    // an earlier cell is free
  } istu_tok_t;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic              ins_we;  // write value into the marked free cell
    logic              ers_we;  // drop the marked matching cell
    logic [ValueW-1:0] value;   // search key and write data
  } istu_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/istu_req_if.sv =====
// ---------------------------------------------------------------------------
// istu_req_if: request channel of the integer set table
// Carries one request word: operation kind and value.
// ---------------------------------------------------------------------------
`default_nettype none

interface istu_req_if;
  import istu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic signed [ValueW-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/istu_rsp_if.sv =====
// ---------------------------------------------------------------------------
// istu_rsp_if: response channel of the integer set table
// Carries one result word: status, element count and empty flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface istu_rsp_if;
  import istu_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  count;
  logic               is_empty;

  modport source (output valid, status, count, is_empty, input ready);
  modport sink   (input valid, status, count, is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/istu_cell.sv =====
// ---------------------------------------------------------------------------
// istu_cell: one entry of the integer set table
// Holds one value and its valid bit, compares it when the search token
// passes, remembers whether it matched or was the first free entry, and
// applies the broadcast commit to itself.
// ---------------------------------------------------------------------------
`default_nettype none

module istu_cell
  import istu_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  istu_tok_t tok_i,
  input  istu_cmd_t cmd_i,
  output istu_tok_t tok_o,
  output logic      valid_o
);

  logic [ValueW-1:0] value_q;
  logic              valid_q;
  logic              hit_mark_q;
  logic              free_mark_q;
  istu_tok_t         tok_q;
  logic              my_hit;
  logic              my_free;

  // Compare against the key; only the first free cell claims the slot
  assign my_hit  = valid_q && (value_q == cmd_i.value);
  assign my_free = !valid_q && !tok_i.free;

  // Pass the token on, folding in this cell's result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q.active <= tok_i.active;
      tok_q.hit    <= tok_i.hit | my_hit;
      tok_q.free   <= tok_i.free | my_free;
    end
  end

  // Remember this cell's role while the token passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_mark_q  <= 1'b0;
      free_mark_q <= 1'b0;
    end else if (tok_i.active) begin
      hit_mark_q  <= my_hit;
      free_mark_q <= my_free;
    end
  end

  // Apply the commit: fill the marked free cell or drop the marked hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.ins_we && free_mark_q) begin
      valid_q <= 1'b1;
    end else if (cmd_i.ers_we && hit_mark_q) begin
      valid_q <= 1'b0;
    end
  end

  // Stored value needs no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_we && free_mark_q) begin
      value_q <= cmd_i.value;
    end
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== rtl/integer_set_table_unit.sv =====
// ---------------------------------------------------------------------------
// integer_set_table_unit: bounded set of 32-bit signed integers
// Insert, erase and membership query over a chain of Capacity cells.
// ---------------------------------------------------------------------------
// A request is taken only while idle; its search token then walks the cell
//   chain one cell per cycle, and the result is loaded once the token leaves
//   the chain's end and any waiting result has been taken.
// The result register lets a new request start while a result waits.
// Reset clears every valid bit, the element count and all handshakes at once.
`default_nettype none

module integer_set_table_unit
  import istu_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  istu_req_if.sink     req_i,
  istu_rsp_if.source   rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [KindW-1:0]    kind_q;
  logic [ValueW-1:0]   value_q;
  logic                hit_q;
  logic                free_q;
  istu_tok_t           tok0_q, tok0_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  out_status_q;
  logic [CountW-1:0]   out_cnt_q;
  logic                out_empty_q;

  istu_tok_t           tok [Capacity+1];
  logic [Capacity-1:0] valid_vec;
  istu_cmd_t           cmd;
  logic                req_fire;
  logic                drain_ok;
  logic                commit;
  logic [StatusW-1:0]  status_c;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign drain_ok    = !out_valid_q || rsp_o.ready;
  assign commit      = (state_q == S_DONE) && drain_ok;

  // Cell chain
  assign tok[0] = tok0_q;
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    istu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[i]),
      .cmd_i   (cmd),
      .tok_o   (tok[i+1]),
      .valid_o (valid_vec[i])
    );
  end

  // Decide status and count change from the finished search
  always_comb begin
    status_c   = ST_MISS;
    cnt_d      = cnt_q;
    cmd.value  = value_q;
    cmd.ins_we = 1'b0;
    cmd.ers_we = 1'b0;
    case (kind_q)
      KIND_INSERT: begin
        if (hit_q) begin
          status_c = ST_MISS;
        end else if (!free_q) begin
          status_c = ST_FULL;
        end else begin
          status_c   = ST_OK;
          cmd.ins_we = commit;
          if (commit) cnt_d = cnt_q + CntW'(1);
        end
      end
      KIND_ERASE: begin
        if (hit_q) begin
          status_c   = ST_OK;
          cmd.ers_we = commit;
          if (commit && (cnt_q != '0)) cnt_d = cnt_q - CntW'(1);
        end
      end
      default: begin
        status_c = hit_q ? ST_OK : ST_MISS;
      end
    endcase
  end

  // Sequence one request: launch token, wait for chain end, commit
  always_comb begin
    state_d     = state_q;
    tok0_d      = '0;
    out_valid_d = out_valid_q && !rsp_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          tok0_d.active = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok[Capacity].active) state_d = S_DONE;
      end
      S_DONE: begin
        if (drain_ok) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tok0_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tok0_q      <= tok0_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q  <= req_i.kind;
      value_q <= req_i.value;
    end
    if ((state_q == S_SCAN) && tok[Capacity].active) begin
      hit_q  <= tok[Capacity].hit;
      free_q <= tok[Capacity].free;
    end
    if (commit) begin
      out_status_q <= status_c;
      out_cnt_q    <= CountW'(cnt_d);
      out_empty_q  <= (cnt_d == '0);
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.count    = out_cnt_q;
  assign rsp_o.is_empty = out_empty_q;

  // Count always matches the valid bits held by the cells
  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CntW'($countones(valid_vec)))
    else $error("element count differs from valid cells");

  // At most one search token at the head and the end of the chain
  a_one_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok0_q.active, tok[Capacity].active}))
    else $error("more than one search token in flight");

  // Token only travels while scanning
  a_tok_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[Capacity].active |-> state_q == S_SCAN)
    else $error("chain end token outside scan");

  // A commit always loads a result
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && state_q == S_IDLE)
    else $error("commit did not present a result");

endmodule

`default_nettype wire
